### rtl/fifo_queue_with_search_assert.svh
// Assertion macros shared by the queue checker.
`ifndef FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH
`define FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define FQS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("queue checker: assertion failed");

// Check a property on every clock edge, reset included.
`define FQS_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("queue checker: assertion failed during reset");

`endif

### rtl/fqs_pkg.sv
// Types, constants and helpers shared by the searchable queue.
package fqs_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_ENQ  = 2'd0,
      CMD_DEQ  = 2'd1,
      CMD_PEEK = 2'd2,
      CMD_FIND = 2'd3
   } fqs_cmd_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } fqs_status_type;

   typedef struct packed {
      fqs_cmd_type cmd;
      logic [31:0] value;
   } fqs_req_type;

   typedef struct packed {
      fqs_status_type status;
      logic [31:0]    data_out;
      logic           found;
      logic [4:0]     entries;
   } fqs_rsp_type;

   typedef struct packed {
      logic                  we;
      logic [IDX_W-1:0]      waddr;
      logic [DATA_WIDTH-1:0] wdata;
      logic [IDX_W-1:0]      raddr;
   } fqs_mem_req_type;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] p);
      return (p == IDX_W'(DEPTH - 1)) ? '0 : p + IDX_W'(1);
   endfunction

endpackage

### rtl/fqs_store.sv
// Ring store of queue words: one write port, one registered read port.
module fqs_store
   import fqs_pkg::*;
(
   input  logic                  clock,
   input  fqs_mem_req_type       mem_req,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rd_data_ff <= mem[mem_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/fqs_ctrl.sv
// Command sequencer with the search compare unit and the result register.
module fqs_ctrl
   import fqs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fqs_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output fqs_rsp_type           rsp_data,
   output fqs_mem_req_type       mem_req,
   input  logic [DATA_WIDTH-1:0] rd_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_SEARCH,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [IDX_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   fqs_cmd_type           cmd_ff, cmd_in;
   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic [CNT_W-1:0]      left_ff, left_in;
   fqs_status_type        status_ff, status_in;
   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic                  found_ff, found_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   fqs_rsp_type           rsp_ff, rsp_in;
   logic                  accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      word_in       = word_ff;
      pos_in        = pos_ff;
      left_in       = left_ff;
      status_in     = status_ff;
      data_in       = data_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      mem_req.we    = 1'b0;
      mem_req.waddr = tail_ff;
      mem_req.wdata = DATA_WIDTH'(req_data.value);
      mem_req.raddr = head_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in    = req_data.cmd;
               word_in   = DATA_WIDTH'(req_data.value);
               status_in = ST_DONE;
               data_in   = '0;
               found_in  = 1'b0;
               state_in  = S_DONE;
               case (req_data.cmd)
                  CMD_ENQ: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_req.we = 1'b1;
                        tail_in    = next_idx(tail_ff);
                        count_in   = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_DEQ, CMD_PEEK: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  CMD_FIND: begin
                     if (count_ff != '0) begin
                        pos_in   = head_ff;
                        left_in  = count_ff;
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            data_in = rd_data;
            if (cmd_ff == CMD_DEQ) begin
               head_in  = next_idx(head_ff);
               count_in = count_ff - CNT_W'(1);
            end
            state_in = S_DONE;
         end
         S_SEARCH: begin
            if (rd_data == word_ff) begin
               found_in = 1'b1;
            end
            mem_req.raddr = next_idx(pos_ff);
            pos_in        = next_idx(pos_ff);
            left_in       = left_ff - CNT_W'(1);
            if (left_ff == CNT_W'(1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_in.status   = status_ff;
               rsp_in.data_out = 32'(data_ff);
               rsp_in.found    = found_ff;
               rsp_in.entries  = 5'(count_ff);
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff    <= cmd_in;
      word_ff   <= word_in;
      pos_ff    <= pos_in;
      left_ff   <= left_in;
      status_ff <= status_in;
      data_ff   <= data_in;
      found_ff  <= found_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/fifo_queue_with_search.sv
// Top level of the searchable first-in first-out queue.
//
//   channel   direction  handshake          payload
//   req_      in         req_valid/stall    fqs_req_type  (cmd, value)
//   rsp_      out        rsp_valid/stall    fqs_rsp_type  (status, data_out, found, entries)
//
// Enqueue and any refused or empty command go from idle straight to the done state; dequeue
// and peek pass a read state first; a search of N held words visits each one in the search
// state, one compare per cycle on the single read port of the ring store.
// Synchronous active-high reset empties the queue; store contents are not cleared.
// The result register holds an item under rsp_stall while the next command is taken;
// req_stall stays high from acceptance until the result is loaded.
module fifo_queue_with_search
   import fqs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  fqs_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output fqs_rsp_type rsp_data
);

   fqs_mem_req_type       mem_req;
   logic [DATA_WIDTH-1:0] rd_data;

   fqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

   fqs_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

### rtl/fqs_checker.sv
// Port-level checker for the searchable queue, bound to the top level.
`include "fifo_queue_with_search_assert.svh"

module fqs_checker
   import fqs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input fqs_rsp_type rsp_data
);

   `FQS_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid)

   `FQS_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))

   `FQS_ASSERT(a_entries_bound, rsp_valid |-> rsp_data.entries <= 5'(DEPTH))

   `FQS_ASSERT(a_empty_clean, rsp_valid && rsp_data.status == ST_EMPTY |-> rsp_data.data_out == '0 && !rsp_data.found && rsp_data.entries == '0)

   `FQS_ASSERT(a_full_count, rsp_valid && rsp_data.status == ST_FULL |-> rsp_data.entries == 5'(DEPTH) && !rsp_data.found)

endmodule

bind fifo_queue_with_search fqs_checker u_fqs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### sim/fifo_queue_with_search_chk.sv
`timescale 1ns / 100ps
// Checker for the searchable queue: tracks the queue contents, predicts each reply and compares.
module fifo_queue_with_search_chk
   import fqs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  fqs_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  fqs_rsp_type rsp_data,
   output int          fail_count = 0,
   output int          replies_pending = 0
);

   logic [DATA_WIDTH-1:0] slots [DEPTH];
   logic [IDX_W-1:0]      oldest    = '0;
   logic [IDX_W-1:0]      free_slot = '0;
   logic [CNT_W-1:0]      held      = '0;
   fqs_rsp_type           replies_due [$];
   int                    errors = 0;

   function automatic logic [IDX_W-1:0] step_slot(input logic [IDX_W-1:0] p);
      return IDX_W'((int'(p) + 1) % DEPTH);
   endfunction

   task automatic apply_command(input fqs_req_type cmd_item, output fqs_rsp_type reply);
      logic [DATA_WIDTH-1:0] word;
      logic [IDX_W-1:0]      pos;
      word         = cmd_item.value[DATA_WIDTH-1:0];
      reply        = '0;
      reply.status = ST_DONE;
      case (cmd_item.cmd)
         CMD_ENQ: begin
            if (held == CNT_W'(DEPTH)) begin
               reply.status = ST_FULL;
            end else begin
               slots[free_slot] = word;
               free_slot        = step_slot(free_slot);
               held             = held + 1'b1;
            end
         end
         CMD_DEQ, CMD_PEEK: begin
            if (held == '0) begin
               reply.status = ST_EMPTY;
            end else begin
               reply.data_out = 32'(slots[oldest]);
               if (cmd_item.cmd == CMD_DEQ) begin
                  oldest = step_slot(oldest);
                  held   = held - 1'b1;
               end
            end
         end
         default: begin
            pos = oldest;
            for (int k = 0; k < int'(held); k++) begin
               if (slots[pos] == word) begin
                  reply.found = 1'b1;
               end
               pos = step_slot(pos);
            end
         end
      endcase
      reply.entries = 5'(held);
   endtask

   always @(posedge clock) begin : watch
      fqs_rsp_type want;
      fqs_rsp_type got;
      if (reset) begin
         oldest    = '0;
         free_slot = '0;
         held      = '0;
         replies_due.delete();
      end else begin
         if (req_valid && !req_stall) begin
            apply_command(req_data, want);
            replies_due.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (replies_due.size() == 0) begin
               $error("reply with no command outstanding: %h", got);
               errors++;
            end else begin
               want = replies_due.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  errors++;
               end
               if (got.data_out !== want.data_out) begin
                  $error("data_out: expected %h, got %h", want.data_out, got.data_out);
                  errors++;
               end
               if (got.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, got.found);
                  errors++;
               end
               if (got.entries !== want.entries) begin
                  $error("entries: expected %0d, got %0d", want.entries, got.entries);
                  errors++;
               end
            end
         end
      end
      replies_pending <= replies_due.size();
      fail_count      <= errors;
   end

endmodule

### sim/fifo_queue_with_search_tb.sv
`timescale 1ns / 100ps
// Testbench top for the searchable queue: clock, reset, command stimulus and verdict.
module fifo_queue_with_search_tb;
   import fqs_pkg::*;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   fqs_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   fqs_rsp_type rsp_data;
   int          fail_count;
   int          replies_pending;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   logic [31:0] recent_words [16] = '{default: '0};
   int          recent_fill = 0;
   bit          filling     = 1'b1;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   fifo_queue_with_search dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   fifo_queue_with_search_chk chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .replies_pending (replies_pending)
   );

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic send_command(input fqs_cmd_type op, input logic [31:0] word);
      fqs_req_type item;
      item.cmd   = op;
      item.value = word;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      if (op == CMD_ENQ) begin
         recent_words[recent_fill % 16] = word;
         recent_fill++;
      end
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3:    return 32'($urandom_range(7));
         4, 5:    return recent_words[$urandom_range(15)];
         default: return $urandom;
      endcase
   endfunction

   function automatic fqs_cmd_type pick_cmd(input bit grow);
      int r;
      r = $urandom_range(99);
      if (r < (grow ? 55 : 20)) return CMD_ENQ;
      if (r < (grow ? 75 : 65)) return CMD_DEQ;
      if (r < (grow ? 87 : 80)) return CMD_PEEK;
      return CMD_FIND;
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_command(CMD_DEQ, 32'h0);
      send_command(CMD_PEEK, 32'hFFFF_FFFF);
      send_command(CMD_FIND, 32'h0);
      send_command(CMD_ENQ, 32'h0);
      send_command(CMD_ENQ, 32'hFFFF_FFFF);
      send_command(CMD_PEEK, 32'h0);
      send_command(CMD_FIND, 32'hFFFF_FFFF);
      send_command(CMD_FIND, 32'h1234_5678);
      send_command(CMD_DEQ, 32'h0);
      for (int i = 0; i < 16; i++) begin
         send_command(CMD_ENQ, 32'hA5A5_0000 | 32'(i));
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 86;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 86;
            end
            default: begin
               send_idle_pct  = 38;
               recv_stall_pct = 38;
            end
         endcase
         for (int n = 0; n < 175; n++) begin
            if ($urandom_range(29) == 0) begin
               filling = !filling;
            end
            send_command(pick_cmd(filling), pick_word());
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("fifo_queue_with_search regression: pass");
      end else begin
         $display("fifo_queue_with_search regression: fail");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("fifo_queue_with_search regression: fail");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/fqs_pkg.sv
rtl/fqs_store.sv
rtl/fqs_ctrl.sv
rtl/fifo_queue_with_search.sv
rtl/fqs_checker.sv
sim/fifo_queue_with_search_chk.sv
sim/fifo_queue_with_search_tb.sv
